// ----- rtl/core/dtt_pkg.sv -----
package dtt_pkg;

  localparam int ENTRIES     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W        = 32;
  localparam int TIME_W      = 48;
  localparam int SLOT_W      = TIME_W + ID_W;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BUF_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_ARM    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

// ----- rtl/core/deadline_timeout_table_core.sv -----
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------------
// request   | start, busy          | in_mode, in_entry_id, in_rel_timeout, in_now
// result    | out_valid (strobe)   | out_expired_valid, out_expired_id, out_last,
//           |                      | out_status, out_earliest_valid, out_earliest_deadline
//
// Slot ids and deadlines live in one synchronous memory that is swept one entry
// per cycle. Arm and cancel take one sweep to find the id and one to find the
// earliest deadline, then give one result. A tick takes k + 1 sweeps for k
// expired ids (k at most MAX_RESULTS), then gives max(k, 1) results.
// Reset (synchronous, rst_n low) clears the slot valid bits and returns to idle.
// Results come one per cycle, back to back; the receiver cannot stall them.
module deadline_timeout_table_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [dtt_pkg::ID_W-1:0]    in_entry_id,
  input  logic [31:0]                 in_rel_timeout,
  input  logic [dtt_pkg::TIME_W-1:0]  in_now,
  output logic                        out_valid,
  output logic                        out_expired_valid,
  output logic [dtt_pkg::ID_W-1:0]    out_expired_id,
  output logic                        out_last,
  output logic [1:0]                  out_status,
  output logic                        out_earliest_valid,
  output logic [dtt_pkg::TIME_W-1:0]  out_earliest_deadline
);
  import dtt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [SLOT_W-1:0] slot_mem [ENTRIES];
  logic [ID_W-1:0]   exp_buf  [MAX_RESULTS];

  state_t              state_r, state_nxt;
  logic [1:0]          req_mode_r, req_mode_nxt;
  logic [ID_W-1:0]     req_id_r, req_id_nxt;
  logic [TIME_W-1:0]   req_dl_r, req_dl_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [IDX_W-1:0]    scan_addr_r, scan_addr_nxt;
  logic                scan_act_r, scan_act_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0]   rd_slot_r;
  logic                best_v_r, best_v_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [SLOT_W-1:0]   best_r, best_nxt;
  logic                match_r, match_nxt;
  logic [IDX_W-1:0]    match_idx_r, match_idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic [ENTRIES-1:0]  slot_valid_r, slot_valid_nxt;
  logic                earl_v_r, earl_v_nxt;
  logic [TIME_W-1:0]   earl_dl_r, earl_dl_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_exp_v_r, out_exp_v_nxt;
  logic [ID_W-1:0]     out_exp_id_r;
  logic                out_last_r, out_last_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_earl_v_r, out_earl_v_nxt;
  logic [TIME_W-1:0]   out_earl_dl_r, out_earl_dl_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic                buf_we;
  logic [ID_W-1:0]     buf_wdata;

  logic                rd_slot_valid, hit, scan_done, better;
  logic                free_any;
  logic [IDX_W-1:0]    free_idx;
  logic                found;
  logic [IDX_W-1:0]    found_idx;
  logic                fin_v;
  logic [IDX_W-1:0]    fin_idx;
  logic [SLOT_W-1:0]   fin_slot;
  logic                emit_last;
  logic [TIME_W:0]     dl_sum;

  assign rd_slot_valid = slot_valid_r[rd_idx_r];
  assign scan_done     = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign hit           = rd_vld_r && rd_slot_valid && (rd_slot_r[ID_W-1:0] == req_id_r);
  // Order by deadline first and id second: the deadline sits in the upper bits.
  assign better        = rd_vld_r && rd_slot_valid && (!best_v_r || (rd_slot_r < best_r));
  assign found         = match_r || hit;
  assign found_idx     = hit ? rd_idx_r : match_idx_r;
  assign fin_v         = best_v_r || better;
  assign fin_idx       = better ? rd_idx_r : best_idx_r;
  assign fin_slot      = better ? rd_slot_r : best_r;
  assign emit_last     = (cnt_r == '0) || (emit_idx_r == cnt_r - CNT_W'(1));
  assign dl_sum        = {1'b0, in_now} + {{(TIME_W - 31){1'b0}}, in_rel_timeout};

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    req_mode_nxt    = req_mode_r;
    req_id_nxt      = req_id_r;
    req_dl_nxt      = req_dl_r;
    now_nxt         = now_r;
    status_nxt      = status_r;
    scan_addr_nxt   = scan_addr_r;
    scan_act_nxt    = scan_act_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    best_v_nxt      = best_v_r;
    best_idx_nxt    = best_idx_r;
    best_nxt        = best_r;
    match_nxt       = match_r;
    match_idx_nxt   = match_idx_r;
    cnt_nxt         = cnt_r;
    emit_idx_nxt    = emit_idx_r;
    slot_valid_nxt  = slot_valid_r;
    earl_v_nxt      = earl_v_r;
    earl_dl_nxt     = earl_dl_r;
    out_valid_nxt   = 1'b0;
    out_exp_v_nxt   = out_exp_v_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;
    out_earl_v_nxt  = out_earl_v_r;
    out_earl_dl_nxt = out_earl_dl_r;
    mem_we          = 1'b0;
    mem_waddr       = found_idx;
    buf_we          = 1'b0;
    buf_wdata       = fin_slot[ID_W-1:0];

    // Read issue side of the sweep: one address per cycle.
    if (scan_act_r) begin
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = scan_addr_r;
      if (scan_addr_r == LAST_IDX) begin
        scan_act_nxt = 1'b0;
      end else begin
        scan_addr_nxt = scan_addr_r + IDX_W'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_mode_nxt  = in_mode;
          req_id_nxt    = in_entry_id;
          req_dl_nxt    = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
          now_nxt       = in_now;
          status_nxt    = STAT_OK;
          cnt_nxt       = '0;
          scan_addr_nxt = '0;
          scan_act_nxt  = 1'b1;
          match_nxt     = 1'b0;
          best_v_nxt    = 1'b0;
          if (in_mode == MODE_ARM || in_mode == MODE_CANCEL) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_FIND: begin
        if (hit) begin
          match_nxt     = 1'b1;
          match_idx_nxt = rd_idx_r;
        end
        if (scan_done) begin
          if (req_mode_r == MODE_ARM) begin
            if (found || free_any) begin
              mem_we                    = 1'b1;
              mem_waddr                 = found ? found_idx : free_idx;
              slot_valid_nxt[mem_waddr] = 1'b1;
            end else begin
              status_nxt = STAT_FULL;
            end
          end else begin
            if (found) begin
              slot_valid_nxt[found_idx] = 1'b0;
            end else begin
              status_nxt = STAT_UNKNOWN;
            end
          end
          scan_addr_nxt = '0;
          scan_act_nxt  = 1'b1;
          best_v_nxt    = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (better) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = rd_slot_r;
        end
        if (scan_done) begin
          // A due entry found by this sweep is expired and another sweep follows while the
          // result buffer has room; otherwise this sweep also gives the earliest deadline.
          if (req_mode_r == MODE_TICK && fin_v && fin_slot[SLOT_W-1:ID_W] <= now_r &&
              cnt_r < CNT_W'(MAX_RESULTS)) begin
            buf_we                  = 1'b1;
            slot_valid_nxt[fin_idx] = 1'b0;
            cnt_nxt                 = cnt_r + CNT_W'(1);
            scan_addr_nxt           = '0;
            scan_act_nxt            = 1'b1;
            best_v_nxt              = 1'b0;
          end else begin
            earl_v_nxt   = fin_v;
            earl_dl_nxt  = fin_v ? fin_slot[SLOT_W-1:ID_W] : '0;
            emit_idx_nxt = '0;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        out_valid_nxt   = 1'b1;
        out_exp_v_nxt   = (cnt_r != '0);
        out_last_nxt    = emit_last;
        out_status_nxt  = status_r;
        out_earl_v_nxt  = earl_v_r;
        out_earl_dl_nxt = earl_dl_r;
        emit_idx_nxt    = emit_idx_r + CNT_W'(1);
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= {req_dl_r, req_id_r};
    end
    if (scan_act_r) begin
      rd_slot_r <= slot_mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      exp_buf[cnt_r[BUF_W-1:0]] <= buf_wdata;
    end
    if (state_r == S_EMIT) begin
      out_exp_id_r <= (cnt_r != '0) ? exp_buf[emit_idx_r[BUF_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_act_r   <= 1'b0;
      rd_vld_r     <= 1'b0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_act_r   <= scan_act_nxt;
      rd_vld_r     <= rd_vld_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_mode_r    <= req_mode_nxt;
    req_id_r      <= req_id_nxt;
    req_dl_r      <= req_dl_nxt;
    now_r         <= now_nxt;
    status_r      <= status_nxt;
    scan_addr_r   <= scan_addr_nxt;
    rd_idx_r      <= rd_idx_nxt;
    best_v_r      <= best_v_nxt;
    best_idx_r    <= best_idx_nxt;
    best_r        <= best_nxt;
    match_r       <= match_nxt;
    match_idx_r   <= match_idx_nxt;
    cnt_r         <= cnt_nxt;
    emit_idx_r    <= emit_idx_nxt;
    earl_v_r      <= earl_v_nxt;
    earl_dl_r     <= earl_dl_nxt;
    out_exp_v_r   <= out_exp_v_nxt;
    out_last_r    <= out_last_nxt;
    out_status_r  <= out_status_nxt;
    out_earl_v_r  <= out_earl_v_nxt;
    out_earl_dl_r <= out_earl_dl_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_expired_valid     = out_exp_v_r;
  assign out_expired_id        = out_exp_id_r;
  assign out_last              = out_last_r;
  assign out_status            = out_status_r;
  assign out_earliest_valid    = out_earl_v_r;
  assign out_earliest_deadline = out_earl_dl_r;

  a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && out_last))
    else $error("request finished without a final result");

  a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a result burst");

  a_expired_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expired_valid) |-> (out_status == STAT_OK))
    else $error("expired id reported with an error status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cnt_r <= CNT_W'(MAX_RESULTS)))
    else $error("expired count beyond result limit");

endmodule
